/* rtl/fitness_telemetry_aggregator_top_macros.svh */
// assertion macros shared by the aggregator rtl
// expects signals named clock and reset in the including module
`ifndef FITNESS_TELEMETRY_AGGREGATOR_TOP_MACROS_SVH
`define FITNESS_TELEMETRY_AGGREGATOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define FTA_ASSERT_NOW(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error(msg);

// next-cycle implication, off during reset
`define FTA_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/fta_pkg.sv */
// shared widths and divider handshake types for the telemetry aggregator
// no dependencies
package fta_pkg;

   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 32;
   localparam int QUOT_W     = 16;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/fta_div.sv */
// serial restoring divider, one quotient bit per cycle, low quotient bits kept
// depends on fta_pkg and the shared assertion macros
`include "fitness_telemetry_aggregator_top_macros.svh"

module fta_div (
   input  logic                clock,
   input  logic                reset,
   input  fta_pkg::div_req_type div_req,
   output fta_pkg::div_rsp_type div_rsp
);
   import fta_pkg::*;

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [QUOT_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   assign rem_shift = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits are enough
         rem_in = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `FTA_ASSERT_NOW(a_div_no_restart, div_req.start, !busy_ff, "divider restarted while busy")
   `FTA_ASSERT_NEXT(a_div_finish, busy_ff && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1) && !div_req.start,
      done_ff && !busy_ff, "divider did not finish after last step")
   `FTA_ASSERT_NOW(a_div_rem_bound, busy_ff && dvs_ff != '0, rem_ff < dvs_ff,
      "partial remainder not below divisor")

endmodule

/* rtl/fitness_telemetry_aggregator_top.sv */
// Bike telemetry aggregator. Input words are events (start, live sample,
// tick, stop); output words are interim records from live samples and full
// records from enabled ticks. csr_wr_en/csr_wr_data set the idle interval
// in ms (1000 after reset); the user writes it only while the block is idle,
// which the block does not enforce. req_ready is high only when the
// sequencer is idle: one event at a time. Start, stop and dropped ticks
// finish in the accept cycle. A live sample's record is registered in the
// sequencer, then moved to the output register once it is free. An emitting
// tick runs the two averages one after the other through a shared serial
// divider, one quotient bit per cycle over 48 bits, before its record is sent.
// Records sit in an output register until rsp_ready takes them; while one
// is waiting the next event is still accepted and worked on, and its record
// waits in the sequencer until the output register frees up.
// Synchronous reset clears the session state, disables ticks, drops any
// pending record and restores the idle interval.
// depends on fta_pkg, fta_div and the shared assertion macros
`include "fitness_telemetry_aggregator_top_macros.svh"

module fitness_telemetry_aggregator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic        req_has_odometer,
   input  logic [31:0] req_odometer_m,
   input  logic        req_has_power,
   input  logic [15:0] req_power_w,
   input  logic        req_has_cadence,
   input  logic [15:0] req_cadence_rpm,
   input  logic        req_has_speed,
   input  logic [15:0] req_speed_centi_kph,
   input  logic [1:0]  req_changed_mask,
   input  logic [31:0] req_now_ms,
   input  logic        req_queue_full,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_kind,
   output logic [5:0]  rsp_present_mask,
   output logic [15:0] rsp_speed_out,
   output logic [15:0] rsp_cadence_out,
   output logic [15:0] rsp_avg_cadence_out,
   output logic [15:0] rsp_power_out,
   output logic [15:0] rsp_avg_power_out,
   output logic [31:0] rsp_distance_out,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import fta_pkg::*;

   typedef enum logic [1:0] {OP_START, OP_LIVE, OP_TICK, OP_STOP} op_type;
   typedef enum logic [1:0] {ST_IDLE, ST_DIV_CAD, ST_DIV_PWR, ST_EMIT} state_type;

   localparam logic KIND_INTERIM = 1'b0;
   localparam logic KIND_FULL    = 1'b1;

   localparam int M_SPEED = 0;
   localparam int M_CAD   = 1;
   localparam int M_ACAD  = 2;
   localparam int M_PWR   = 3;
   localparam int M_APWR  = 4;
   localparam int M_DIST  = 5;

   localparam logic [15:0] IDLE_RESET = 16'd1000;

   state_type        state_ff, state_in;
   logic             ticking_ff, ticking_in;
   logic             pfresh_ff, pfresh_in;
   logic             cfresh_ff, cfresh_in;
   logic [31:0]      start_odo_ff, start_odo_in;
   logic [DIVIDEND_W-1:0] ptotal_ff, ptotal_in;
   logic [DIVISOR_W-1:0]  pcount_ff, pcount_in;
   logic [DIVIDEND_W-1:0] ctotal_ff, ctotal_in;
   logic [DIVISOR_W-1:0]  ccount_ff, ccount_in;
   logic [31:0]      last_full_ff, last_full_in;
   logic [15:0]      idle_ff, idle_in;

   logic             rec_kind_ff, rec_kind_in;
   logic [5:0]       rec_mask_ff, rec_mask_in;
   logic [15:0]      rec_speed_ff, rec_speed_in;
   logic [15:0]      rec_cad_ff, rec_cad_in;
   logic [15:0]      rec_acad_ff, rec_acad_in;
   logic [15:0]      rec_pwr_ff, rec_pwr_in;
   logic [15:0]      rec_apwr_ff, rec_apwr_in;
   logic [31:0]      rec_dist_ff, rec_dist_in;

   logic             out_valid_ff, out_valid_in;
   logic             out_kind_ff, out_kind_in;
   logic [5:0]       out_mask_ff, out_mask_in;
   logic [15:0]      out_speed_ff, out_speed_in;
   logic [15:0]      out_cad_ff, out_cad_in;
   logic [15:0]      out_acad_ff, out_acad_in;
   logic [15:0]      out_pwr_ff, out_pwr_in;
   logic [15:0]      out_apwr_ff, out_apwr_in;
   logic [31:0]      out_dist_ff, out_dist_in;

   div_req_type      div_req;
   div_rsp_type      div_rsp;

   logic             accept;
   logic [31:0]      since_full;
   logic             idle_elapsed;
   logic             pwr_take;
   logic             cad_take;

   fta_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign since_full   = req_now_ms - last_full_ff;
   assign idle_elapsed = since_full >= {16'b0, idle_ff};
   // nonzero samples count until the sample counter saturates
   assign pwr_take = req_has_power && (req_power_w != '0) && (pcount_ff != '1);
   assign cad_take = req_has_cadence && (req_cadence_rpm != '0) && (ccount_ff != '1);

   always_comb begin
      state_in     = state_ff;
      ticking_in   = ticking_ff;
      pfresh_in    = pfresh_ff;
      cfresh_in    = cfresh_ff;
      start_odo_in = start_odo_ff;
      ptotal_in    = ptotal_ff;
      pcount_in    = pcount_ff;
      ctotal_in    = ctotal_ff;
      ccount_in    = ccount_ff;
      last_full_in = last_full_ff;
      idle_in      = idle_ff;
      rec_kind_in  = rec_kind_ff;
      rec_mask_in  = rec_mask_ff;
      rec_speed_in = rec_speed_ff;
      rec_cad_in   = rec_cad_ff;
      rec_acad_in  = rec_acad_ff;
      rec_pwr_in   = rec_pwr_ff;
      rec_apwr_in  = rec_apwr_ff;
      rec_dist_in  = rec_dist_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_mask_in  = out_mask_ff;
      out_speed_in = out_speed_ff;
      out_cad_in   = out_cad_ff;
      out_acad_in  = out_acad_ff;
      out_pwr_in   = out_pwr_ff;
      out_apwr_in  = out_apwr_ff;
      out_dist_in  = out_dist_ff;
      div_req      = '0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         idle_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_operation))
                  OP_START: begin
                     pfresh_in    = 1'b0;
                     cfresh_in    = 1'b0;
                     start_odo_in = req_has_odometer ? req_odometer_m : '0;
                     ptotal_in    = '0;
                     pcount_in    = '0;
                     ctotal_in    = '0;
                     ccount_in    = '0;
                     last_full_in = '0;
                     ticking_in   = 1'b1;
                  end
                  OP_STOP: begin
                     ticking_in = 1'b0;
                  end
                  OP_LIVE: begin
                     // a zero odometer reading counts as unknown
                     if (start_odo_ff == '0 && req_has_odometer) begin
                        start_odo_in = req_odometer_m;
                     end
                     rec_kind_in          = KIND_INTERIM;
                     rec_mask_in          = '0;
                     rec_mask_in[M_PWR]   = req_changed_mask[0];
                     rec_mask_in[M_CAD]   = req_changed_mask[1];
                     rec_speed_in         = '0;
                     rec_cad_in           = req_changed_mask[1] ? req_cadence_rpm : '0;
                     rec_acad_in          = '0;
                     rec_pwr_in           = req_changed_mask[0] ? req_power_w : '0;
                     rec_apwr_in          = '0;
                     rec_dist_in          = '0;
                     pfresh_in = req_queue_full ? 1'b0 : (pfresh_ff || req_changed_mask[0]);
                     cfresh_in = req_queue_full ? 1'b0 : (cfresh_ff || req_changed_mask[1]);
                     if (pwr_take) begin
                        ptotal_in = ptotal_ff + {{(DIVIDEND_W-16){1'b0}}, req_power_w};
                        pcount_in = pcount_ff + 1'b1;
                     end
                     if (cad_take) begin
                        ctotal_in = ctotal_ff + {{(DIVIDEND_W-16){1'b0}}, req_cadence_rpm};
                        ccount_in = ccount_ff + 1'b1;
                     end
                     state_in = ST_EMIT;
                  end
                  OP_TICK: begin
                     if (ticking_ff && (pfresh_ff || cfresh_ff || idle_elapsed)) begin
                        rec_kind_in         = KIND_FULL;
                        rec_mask_in         = '0;
                        rec_mask_in[M_SPEED] = req_has_speed;
                        rec_mask_in[M_CAD]  = req_has_cadence && !cfresh_ff;
                        rec_mask_in[M_ACAD] = (ccount_ff != '0);
                        rec_mask_in[M_PWR]  = req_has_power && !pfresh_ff;
                        rec_mask_in[M_APWR] = (pcount_ff != '0);
                        rec_mask_in[M_DIST] = req_has_odometer && (start_odo_ff != '0);
                        rec_speed_in = req_has_speed ? req_speed_centi_kph : '0;
                        rec_cad_in   = (req_has_cadence && !cfresh_ff) ? req_cadence_rpm : '0;
                        rec_pwr_in   = (req_has_power && !pfresh_ff) ? req_power_w : '0;
                        rec_dist_in  = (req_has_odometer && (start_odo_ff != '0)) ?
                                       (req_odometer_m - start_odo_ff) : '0;
                        pfresh_in    = 1'b0;
                        cfresh_in    = 1'b0;
                        last_full_in = req_now_ms;
                        div_req.start    = 1'b1;
                        div_req.dividend = ctotal_ff;
                        div_req.divisor  = ccount_ff;
                        state_in = ST_DIV_CAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_CAD: begin
            if (div_rsp.done) begin
               rec_acad_in      = (ccount_ff != '0) ? div_rsp.quotient : '0;
               div_req.start    = 1'b1;
               div_req.dividend = ptotal_ff;
               div_req.divisor  = pcount_ff;
               state_in = ST_DIV_PWR;
            end
         end
         ST_DIV_PWR: begin
            if (div_rsp.done) begin
               rec_apwr_in = (pcount_ff != '0) ? div_rsp.quotient : '0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_kind_in  = rec_kind_ff;
               out_mask_in  = rec_mask_ff;
               out_speed_in = rec_speed_ff;
               out_cad_in   = rec_cad_ff;
               out_acad_in  = rec_acad_ff;
               out_pwr_in   = rec_pwr_ff;
               out_apwr_in  = rec_apwr_ff;
               out_dist_in  = rec_dist_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ticking_ff   <= 1'b0;
         pfresh_ff    <= 1'b0;
         cfresh_ff    <= 1'b0;
         start_odo_ff <= '0;
         ptotal_ff    <= '0;
         pcount_ff    <= '0;
         ctotal_ff    <= '0;
         ccount_ff    <= '0;
         last_full_ff <= '0;
         idle_ff      <= IDLE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticking_ff   <= ticking_in;
         pfresh_ff    <= pfresh_in;
         cfresh_ff    <= cfresh_in;
         start_odo_ff <= start_odo_in;
         ptotal_ff    <= ptotal_in;
         pcount_ff    <= pcount_in;
         ctotal_ff    <= ctotal_in;
         ccount_ff    <= ccount_in;
         last_full_ff <= last_full_in;
         idle_ff      <= idle_in;
         out_valid_ff <= out_valid_in;
      end
      rec_kind_ff  <= rec_kind_in;
      rec_mask_ff  <= rec_mask_in;
      rec_speed_ff <= rec_speed_in;
      rec_cad_ff   <= rec_cad_in;
      rec_acad_ff  <= rec_acad_in;
      rec_pwr_ff   <= rec_pwr_in;
      rec_apwr_ff  <= rec_apwr_in;
      rec_dist_ff  <= rec_dist_in;
      out_kind_ff  <= out_kind_in;
      out_mask_ff  <= out_mask_in;
      out_speed_ff <= out_speed_in;
      out_cad_ff   <= out_cad_in;
      out_acad_ff  <= out_acad_in;
      out_pwr_ff   <= out_pwr_in;
      out_apwr_ff  <= out_apwr_in;
      out_dist_ff  <= out_dist_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_record_kind     = out_kind_ff;
   assign rsp_present_mask    = out_mask_ff;
   assign rsp_speed_out       = out_speed_ff;
   assign rsp_cadence_out     = out_cad_ff;
   assign rsp_avg_cadence_out = out_acad_ff;
   assign rsp_power_out       = out_pwr_ff;
   assign rsp_avg_power_out   = out_apwr_ff;
   assign rsp_distance_out    = out_dist_ff;

   `FTA_ASSERT_NOW(a_done_in_div_state, div_rsp.done,
      state_ff == ST_DIV_CAD || state_ff == ST_DIV_PWR, "divider result outside a divide state")
   `FTA_ASSERT_NOW(a_interim_fields, out_valid_ff && out_kind_ff == KIND_INTERIM,
      out_mask_ff[M_SPEED] == 1'b0 && out_mask_ff[M_ACAD] == 1'b0 &&
      out_mask_ff[M_APWR] == 1'b0 && out_mask_ff[M_DIST] == 1'b0,
      "interim word carries full-record fields")
   `FTA_ASSERT_NOW(a_absent_avg_zero, out_valid_ff && !out_mask_ff[M_APWR],
      out_apwr_ff == '0, "absent average power not zero")
   `FTA_ASSERT_NOW(a_empty_sum_zero, pcount_ff == '0 && ccount_ff == '0,
      ptotal_ff == '0 && ctotal_ff == '0, "sum without samples")

endmodule
